// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the pixel blend top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CAB_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("assertion failed");
`define CAB_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define CAB_ASSERT(lbl, clk, rstn, prop)
`define CAB_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/core/cab_pkg.sv -----
// Types and constants of the clipped alpha blend pixel pipeline.
`timescale 1ns / 1ps
package cab_pkg;
	localparam int DIM_W  = 13;
	localparam int PIX_W  = 32;
	localparam int CHAN_W = 8;
	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;
	localparam logic [CHAN_W-1:0] ROUND_HALF = 8'd127;

	typedef enum logic [1:0] {
		CFG_DEST_WIDTH  = 2'd0,
		CFG_DEST_HEIGHT = 2'd1,
		CFG_DRAW_MODE   = 2'd2,
		CFG_FILL_COLOR  = 2'd3
	} cfg_idx_t;

	localparam logic [1:0] MODE_FILL  = 2'd0;
	localparam logic [1:0] MODE_CONST = 2'd1;

	typedef struct packed {
		logic [DIM_W-1:0] dest_width;
		logic [DIM_W-1:0] dest_height;
		logic [1:0]       draw_mode;
		logic [PIX_W-1:0] fill_color;
	} cfg_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} pipe_en_t;

	typedef struct packed {
		logic             write_enable;
		logic [PIX_W-1:0] out_pixel;
	} result_t;
endpackage

// ----- rtl/core/cab_if.sv -----
// Valid/ready stream interfaces for pixel words and result words.
`timescale 1ns / 1ps
interface cab_in_if #(parameter int COORD_BITS = 14);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] pos_x;
	logic signed [COORD_BITS-1:0] pos_y;
	logic [31:0]                  dest_pixel;
	logic [31:0]                  src_pixel;

	modport source (output valid, pos_x, pos_y, dest_pixel, src_pixel, input ready);
	modport sink (input valid, pos_x, pos_y, dest_pixel, src_pixel, output ready);
endinterface

interface cab_out_if;
	logic        valid;
	logic        ready;
	logic        write_enable;
	logic [31:0] out_pixel;

	modport source (output valid, write_enable, out_pixel, input ready);
	modport sink (input valid, write_enable, out_pixel, output ready);
endinterface

// ----- rtl/core/cab_clip.sv -----
// First stage: clip test against the surface and selection of the blend operands.
`timescale 1ns / 1ps
module cab_clip import cab_pkg::*; #(
	parameter int COORD_BITS = 14
) (
	input  logic                         clk,
	input  pipe_en_t                     en,
	input  cfg_t                         cfg,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic [PIX_W-1:0]             dest_pixel,
	input  logic [PIX_W-1:0]             src_pixel,
	output logic                         inside_s1,
	output logic [CHAN_W-1:0]            abyte_s1,
	output logic [CHAN_W-1:0]            alpha_s1,
	output logic [3*CHAN_W-1:0]          src_s1,
	output logic [3*CHAN_W-1:0]          dst_s1
);
	localparam int MAG_W = COORD_BITS - 1;
	localparam int CMP_W = (MAG_W > DIM_W) ? MAG_W : DIM_W;

	logic [CMP_W-1:0]  x_mag, y_mag, w_ext, h_ext;
	logic              on_surf, fill;
	logic [PIX_W-1:0]  color;

	assign x_mag = CMP_W'(pos_x[MAG_W-1:0]);
	assign y_mag = CMP_W'(pos_y[MAG_W-1:0]);
	assign w_ext = CMP_W'(cfg.dest_width);
	assign h_ext = CMP_W'(cfg.dest_height);
	assign on_surf = !pos_x[COORD_BITS-1] && !pos_y[COORD_BITS-1]
		&& (x_mag < w_ext) && (y_mag < h_ext);
	assign fill = (cfg.draw_mode == MODE_FILL);
	assign color = cfg.draw_mode[1] ? src_pixel : cfg.fill_color;

	// Fill mode runs through the blend with full alpha, which returns the color unchanged.
	always_ff @(posedge clk) begin
		if (en.s1) begin
			inside_s1 <= on_surf;
			abyte_s1  <= fill ? cfg.fill_color[PIX_W-1:3*CHAN_W] : '0;
			alpha_s1  <= fill ? CHAN_MAX : color[PIX_W-1:3*CHAN_W];
			src_s1    <= color[3*CHAN_W-1:0];
			dst_s1    <= dest_pixel[3*CHAN_W-1:0];
		end
	end
endmodule

// ----- rtl/core/cab_lane.sv -----
// One color channel: weighted sum, then rounded division by 255.
`timescale 1ns / 1ps
module cab_lane import cab_pkg::*; (
	input  logic              clk,
	input  pipe_en_t          en,
	input  logic [CHAN_W-1:0] alpha,
	input  logic [CHAN_W-1:0] dst_c,
	input  logic [CHAN_W-1:0] src_c,
	output logic [CHAN_W-1:0] mix_s3
);
	logic [15:0] prod_d, prod_s, sum_n, n_s2;
	logic [16:0] m, q_mul, rem;
	logic [24:0] t;
	logic [8:0]  q0, q;

	assign prod_d = {8'h00, ~alpha} * {8'h00, dst_c};
	assign prod_s = {8'h00, alpha} * {8'h00, src_c};
	assign sum_n  = prod_d + prod_s;

	// The estimate m*257/65536 is at most one below m/255, so one correction step suffices.
	assign m     = 17'(n_s2) + 17'(ROUND_HALF);
	assign t     = {m, 8'h00} + 25'(m);
	assign q0    = t[24:16];
	assign q_mul = {q0, 8'h00} - 17'(q0);
	assign rem   = m - q_mul;
	assign q     = (rem >= 17'(CHAN_MAX)) ? q0 + 9'd1 : q0;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			n_s2 <= sum_n;
		end
		if (en.s3) begin
			mix_s3 <= q[CHAN_W-1:0];
		end
	end
endmodule

// ----- rtl/core/cab_skid.sv -----
// Output register with a skid entry so that ready toward the pipeline is registered.
`timescale 1ns / 1ps
module cab_skid import cab_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  result_t in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);
	logic    main_v_q, skid_v_q, push;
	result_t main_q, skid_q;

	assign in_ready  = !skid_v_q;
	assign push      = in_valid && !skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!main_v_q || out_ready) begin
			if (skid_v_q) begin
				main_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_v_q || out_ready) begin
			main_q <= skid_v_q ? skid_q : in_data;
		end else if (push) begin
			skid_q <= in_data;
		end
	end
endmodule

// ----- rtl/core/clipped_alpha_blend_pixel_top.sv -----
// Usage:
// Pixel words enter on the item channel (coordinate, destination word, source word)
// and one result word per pixel leaves on the result channel, both valid/ready.
// A word is taken at a clock edge with valid and ready high on that channel.
// Write the registers through wr_en, wr_index and wr_data only while the block is idle;
// the block itself does not enforce this. Index 0 width, 1 height, 2 draw mode, 3 fill color.
// One word can enter every clock while item ready is high; the result of a word is
// registered in turn by the clip stage, the multiply stage and the divide stage,
// and then by the output register, which presents it.
// Off-surface pixels give write_enable low and a zero pixel.
// When the receiver stalls, the output register and its skid entry hold words
// and the pipeline stages fill up; item ready drops once all stages are full,
// and no word is lost or repeated.
// Reset clears the configuration registers to zero and empties the pipeline.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module clipped_alpha_blend_pixel_top import cab_pkg::*; #(
	parameter int COORD_BITS = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [1:0]       wr_index,
	input  logic [PIX_W-1:0] wr_data,
	cab_in_if.sink           item,
	cab_out_if.source        result
);
	cfg_t     cfg_q;
	pipe_en_t en;
	logic     v_s1, v_s2, v_s3, skid_ready;
	logic     inside_s1, inside_s2, inside_s3;
	logic [CHAN_W-1:0]   abyte_s1, abyte_s2, abyte_s3, alpha_s1;
	logic [3*CHAN_W-1:0] src_s1, dst_s1, rgb_s3;
	result_t  res_s3, res_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				CFG_DEST_WIDTH:  cfg_q.dest_width  <= wr_data[DIM_W-1:0];
				CFG_DEST_HEIGHT: cfg_q.dest_height <= wr_data[DIM_W-1:0];
				CFG_DRAW_MODE:   cfg_q.draw_mode   <= wr_data[1:0];
				CFG_FILL_COLOR:  cfg_q.fill_color  <= wr_data;
				default: ;
			endcase
		end
	end

	assign en.s3 = !v_s3 || skid_ready;
	assign en.s2 = !v_s2 || en.s3;
	assign en.s1 = !v_s1 || en.s2;
	assign item.ready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= item.valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
		end
	end

	cab_clip #(.COORD_BITS(COORD_BITS)) u_clip (
		.clk        (clk),
		.en         (en),
		.cfg        (cfg_q),
		.pos_x      (item.pos_x),
		.pos_y      (item.pos_y),
		.dest_pixel (item.dest_pixel),
		.src_pixel  (item.src_pixel),
		.inside_s1  (inside_s1),
		.abyte_s1   (abyte_s1),
		.alpha_s1   (alpha_s1),
		.src_s1     (src_s1),
		.dst_s1     (dst_s1)
	);

	for (genvar c = 0; c < 3; c++) begin : g_lane
		cab_lane u_lane (
			.clk    (clk),
			.en     (en),
			.alpha  (alpha_s1),
			.dst_c  (dst_s1[c*CHAN_W +: CHAN_W]),
			.src_c  (src_s1[c*CHAN_W +: CHAN_W]),
			.mix_s3 (rgb_s3[c*CHAN_W +: CHAN_W])
		);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			inside_s2 <= inside_s1;
			abyte_s2  <= abyte_s1;
		end
		if (en.s3) begin
			inside_s3 <= inside_s2;
			abyte_s3  <= abyte_s2;
		end
	end

	assign res_s3.write_enable = inside_s3;
	assign res_s3.out_pixel    = inside_s3 ? {abyte_s3, rgb_s3} : '0;

	cab_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (skid_ready),
		.in_data   (res_s3),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (res_out)
	);

	assign result.write_enable = res_out.write_enable;
	assign result.out_pixel    = res_out.out_pixel;

	`CAB_ASSERT_IMPL(a_clip_zero, clk, arst_n, result.valid && !result.write_enable, result.out_pixel == '0)
	`CAB_ASSERT_IMPL(a_blend_alpha, clk, arst_n, result.valid && (cfg_q.draw_mode != MODE_FILL), result.out_pixel[PIX_W-1:3*CHAN_W] == '0)
	`CAB_ASSERT_IMPL(a_stall_full, clk, arst_n, !item.ready, v_s1 && v_s2 && v_s3 && !skid_ready)
	`CAB_ASSERT_IMPL(a_const_mode_rgb, clk, arst_n, v_s3 && inside_s3 && (cfg_q.draw_mode == MODE_CONST), abyte_s3 == '0)
endmodule

// ----- bench/clipped_alpha_blend_pixel_top_test.sv -----
// Self-checking testbench for the clipped alpha blend pixel writer with random stalls.
`timescale 1ns / 1ps
module clipped_alpha_blend_pixel_top_test import cab_pkg::*;;
	localparam int COORD_BITS = 14;
	localparam int PIPE_DEPTH = 3;
	localparam int IDLE_LIMIT = 4000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_WORDS = 155;
	localparam logic [1:0] MODE_IMAGE = 2'd2;
	localparam logic [1:0] MODE_IMAGE_ALT = 2'd3;

	class blend_scoreboard;
		cfg_t cfg;
		result_t pending[$];
		int mismatches;

		function new();
			cfg = '0;
			mismatches = 0;
		endfunction

		function logic [PIX_W-1:0] blend(logic [PIX_W-1:0] top, logic [PIX_W-1:0] under);
			logic [PIX_W-1:0] mixed;
			int unsigned a;
			int unsigned n;
			int c;
			a = {24'd0, top[31:24]};
			mixed = '0;
			for (c = 0; c < 3; c++) begin
				n = (255 - a) * under[c*8 +: 8] + a * top[c*8 +: 8];
				mixed[c*8 +: 8] = 8'((n + 127) / 255);
			end
			return mixed;
		endfunction

		function void note_pixel(logic signed [COORD_BITS-1:0] x, logic signed [COORD_BITS-1:0] y,
				logic [PIX_W-1:0] dst, logic [PIX_W-1:0] src);
			int xi;
			int yi;
			int w;
			int h;
			result_t r;
			xi = int'(x);
			yi = int'(y);
			w = int'(cfg.dest_width);
			h = int'(cfg.dest_height);
			r = '0;
			r.write_enable = xi >= 0 && yi >= 0 && xi < w && yi < h;
			if (r.write_enable) begin
				if (cfg.draw_mode == MODE_FILL)
					r.out_pixel = cfg.fill_color;
				else if (cfg.draw_mode == MODE_CONST)
					r.out_pixel = blend(cfg.fill_color, dst);
				else
					r.out_pixel = blend(src, dst);
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic we, logic [PIX_W-1:0] pix);
			result_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: we=%0b pix=%08h", we, pix);
				return;
			end
			want = pending.pop_front();
			if (we !== want.write_enable || pix !== want.out_pixel) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected we=%0b pix=%08h, got we=%0b pix=%08h",
						want.write_enable, want.out_pixel, we, pix);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [1:0] wr_index;
	logic [PIX_W-1:0] wr_data;
	bit steady;
	blend_scoreboard sb;

	cab_in_if #(.COORD_BITS(COORD_BITS)) pix_in();
	cab_out_if pix_out();

	clipped_alpha_blend_pixel_top #(.COORD_BITS(COORD_BITS)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.item(pix_in),
		.result(pix_out)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [PIX_W-1:0] rand_argb();
		logic [PIX_W-1:0] w;
		w = $urandom;
		case ($urandom_range(0, 6))
			0: w[31:24] = 8'h00;
			1: w[31:24] = 8'hFF;
			default: ;
		endcase
		return w;
	endfunction

	function automatic logic [DIM_W-1:0] rand_dim();
		case ($urandom_range(0, 5))
			0: return DIM_W'(0);
			1: return DIM_W'(1);
			2: return DIM_W'($urandom_range(2, 64));
			3: return DIM_W'(4096);
			4: return DIM_W'(8191);
			default: return DIM_W'($urandom_range(0, 4096));
		endcase
	endfunction

	function automatic logic signed [COORD_BITS-1:0] rand_coord(int limit);
		logic [31:0] r;
		int v;
		r = $urandom;
		if ($urandom_range(0, 9) < 3)
			return r[COORD_BITS-1:0];
		v = $urandom_range(0, limit + 3) - 2;
		return v[COORD_BITS-1:0];
	endfunction

	task automatic send_pixel(int x, int y, logic [PIX_W-1:0] dst, logic [PIX_W-1:0] src);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			pix_in.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_in.pos_x = x[COORD_BITS-1:0];
		pix_in.pos_y = y[COORD_BITS-1:0];
		pix_in.dest_pixel = dst;
		pix_in.src_pixel = src;
		pix_in.valid = 1'b1;
		do
			@(posedge clk);
		while (!pix_in.ready);
		sb.note_pixel(pix_in.pos_x, pix_in.pos_y, dst, src);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		pix_in.valid = 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (PIPE_DEPTH + 1) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [PIX_W-1:0] value);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = value;
		case (idx)
			CFG_DEST_WIDTH: sb.cfg.dest_width = value[DIM_W-1:0];
			CFG_DEST_HEIGHT: sb.cfg.dest_height = value[DIM_W-1:0];
			CFG_DRAW_MODE: sb.cfg.draw_mode = value[1:0];
			default: sb.cfg.fill_color = value;
		endcase
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	task automatic apply_setting(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, logic [1:0] mode,
			logic [PIX_W-1:0] fill);
		wait_idle();
		write_reg(CFG_DEST_WIDTH, PIX_W'(w));
		write_reg(CFG_DEST_HEIGHT, PIX_W'(h));
		write_reg(CFG_DRAW_MODE, PIX_W'(mode));
		write_reg(CFG_FILL_COLOR, fill);
	endtask

	initial begin : result_sink
		int hold;
		hold = 0;
		pix_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				pix_out.ready = 1'b0;
				hold--;
			end else begin
				pix_out.ready = 1'b1;
				hold = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && pix_out.valid && pix_out.ready)
			sb.check_result(pix_out.write_enable, pix_out.out_pixel);
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
				idle = 0;
			else
				idle++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		int p;
		int k;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		sb = new();
		steady = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		pix_in.valid = 1'b0;
		pix_in.pos_x = '0;
		pix_in.pos_y = '0;
		pix_in.dest_pixel = '0;
		pix_in.src_pixel = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// With the reset registers the surface has no pixels at all.
		send_pixel(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		apply_setting(16, 8, MODE_FILL, 32'hA5C3_7E19);
		send_pixel(0, 0, 32'h0000_0000, 32'h0000_0000);
		send_pixel(15, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pixel(16, 7, 32'h1234_5678, 32'h8765_4321);
		send_pixel(15, 8, 32'h1234_5678, 32'h8765_4321);
		send_pixel(-1, 0, 32'h1234_5678, 32'h8765_4321);
		send_pixel(0, -1, 32'h1234_5678, 32'h8765_4321);
		send_pixel(-8192, -8192, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pixel(8191, 8191, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		apply_setting(16, 8, MODE_CONST, 32'h00FF_FFFF);
		send_pixel(1, 1, 32'h1234_5678, 32'hFFFF_FFFF);
		apply_setting(16, 8, MODE_CONST, 32'hFFFF_FFFF);
		send_pixel(2, 2, 32'h0000_0000, 32'h0000_0000);
		apply_setting(16, 8, MODE_CONST, 32'h8000_FF7F);
		send_pixel(3, 3, 32'hFFFF_FFFF, 32'h0000_0000);

		apply_setting(16, 8, MODE_IMAGE, 32'h0000_0000);
		send_pixel(4, 4, 32'hFF9A_BCDE, 32'h00FF_FFFF);
		send_pixel(5, 5, 32'h0000_0000, 32'hFFFF_FFFF);
		send_pixel(6, 6, 32'hFFFF_FFFF, 32'h8000_0000);
		send_pixel(16, 0, 32'hFFFF_FFFF, 32'h8000_0000);

		// The unused mode code behaves like image blending.
		apply_setting(16, 8, MODE_IMAGE_ALT, 32'hFFFF_FFFF);
		send_pixel(7, 7, 32'h0011_2233, 32'h7F44_5566);
		send_pixel(0, 7, 32'hFFFF_FFFF, 32'h01FE_0180);

		apply_setting(4096, 0, MODE_FILL, 32'h5A5A_A5A5);
		send_pixel(0, 0, 32'h0000_0000, 32'h0000_0000);
		apply_setting(4096, 4096, MODE_FILL, 32'hC0FF_EE01);
		send_pixel(4095, 4095, 32'h0000_0000, 32'h0000_0000);
		send_pixel(4096, 0, 32'h0000_0000, 32'h0000_0000);
		send_pixel(0, 4096, 32'h0000_0000, 32'h0000_0000);

		for (p = 0; p < RANDOM_PHASES; p++) begin
			w = rand_dim();
			h = rand_dim();
			apply_setting(w, h, 2'($urandom_range(0, 3)), rand_argb());
			steady = ($urandom_range(0, 3) == 0);
			for (k = 0; k < PHASE_WORDS; k++)
				send_pixel(rand_coord(w), rand_coord(h), rand_argb(), rand_argb());
			steady = 1'b0;
		end

		pix_in.valid = 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (PIPE_DEPTH + 2) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
